/* src/mrrm_pkg.sv */
// ============================================================================
// mrrm_pkg
// Shared constants for the multi-stage range remapper: default sizes,
// fixed field widths and command codes.
// ============================================================================
package mrrm_pkg;

    // Default sizes handed to the top level as parameter defaults.
    localparam int STAGES_DEF      = 7;
    localparam int ENTRIES_DEF     = 64;
    localparam int VALUE_WIDTH_DEF = 48;

    // Fixed widths of the index fields and the configuration register.
    localparam int STAGE_IDX_W = 3;
    localparam int ENTRY_IDX_W = 6;
    localparam int CFG_W       = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'd7;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

endpackage

/* src/multi_stage_range_remap_min.sv */
// ============================================================================
// multi_stage_range_remap_min
// Chained range translation table with a running minimum per set of items.
// ============================================================================
//
//  Channel   Signals                                   Handshake
//  --------  ----------------------------------------  ----------------------
//  command   start, busy, i_command .. i_last_in_set   taken at start & !busy
//  result    o_strobe, o_mapped_value .. o_set_closed  one cycle, no stall
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data      valid & ready
//
//  A write item goes to the entry memory straight from idle and leaves busy low.
//  A map item scans the entry memory one entry per cycle, stage after stage;
//  a hit ends its stage early, and the scan pauses while the first read of
//  the next stage is issued. After reset a clearing pass over all STAGES x
//  ENTRIES_PER_STAGE entries (448 by default) holds busy high. The result
//  side has no back-pressure.
//
module multi_stage_range_remap_min #(
    parameter int STAGES            = mrrm_pkg::STAGES_DEF,
    parameter int ENTRIES_PER_STAGE = mrrm_pkg::ENTRIES_DEF,
    parameter int VALUE_WIDTH       = mrrm_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_command,
    input  logic [mrrm_pkg::STAGE_IDX_W-1:0] i_stage_index,
    input  logic [mrrm_pkg::ENTRY_IDX_W-1:0] i_entry_index,
    input  logic                             i_entry_enable,
    input  logic [VALUE_WIDTH-1:0]           i_entry_source,
    input  logic [VALUE_WIDTH-1:0]           i_entry_destination,
    input  logic [VALUE_WIDTH-1:0]           i_entry_length,
    input  logic [VALUE_WIDTH-1:0]           i_seed_value,
    input  logic                             i_last_in_set,
    // result channel
    output logic                             o_strobe,
    output logic [VALUE_WIDTH-1:0]           o_mapped_value,
    output logic [VALUE_WIDTH-1:0]           o_set_minimum,
    output logic                             o_set_closed,
    // configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mrrm_pkg::CFG_W-1:0]       i_cfg_data
);
    import mrrm_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int DEPTH = STAGES * ENTRIES_PER_STAGE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = 3 * VW + 1;
    localparam int ENT_W = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
    localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    // control registers
    t_state            r_state,       n_state;
    logic [AW-1:0]     r_clr_addr,    n_clr_addr;
    logic [CFG_W-1:0]  r_cfg;
    logic              r_iss_active,  n_iss_active;
    logic              r_rd_vld,      n_rd_vld;
    logic [VW-1:0]     r_run_min,     n_run_min;
    logic              r_set_open,    n_set_open;
    logic              r_out_valid,   n_out_valid;
    // payload and scan position registers
    logic [AW-1:0]     r_iss_addr,    n_iss_addr;
    logic [ENT_W-1:0]  r_iss_entry,   n_iss_entry;
    logic [STG_W-1:0]  r_iss_stage,   n_iss_stage;
    logic [STG_W-1:0]  r_last_stg,    n_last_stg;
    logic              r_dat_last,    n_dat_last;
    logic [STG_W-1:0]  r_dat_stage,   n_dat_stage;
    logic [VW-1:0]     r_value,       n_value;
    logic              r_last_in_set, n_last_in_set;
    logic [VW-1:0]     r_out_mapped,  n_out_mapped;
    logic [VW-1:0]     r_out_min,     n_out_min;
    logic              r_out_closed,  n_out_closed;

    // table ports
    logic              tbl_wr_en;
    logic [AW-1:0]     tbl_wr_addr;
    logic [DW-1:0]     tbl_wr_data;
    logic              tbl_rd_en;
    logic [DW-1:0]     tbl_rd_data;

    // fields of the entry read last cycle
    logic              ent_valid;
    logic [VW-1:0]     ent_source;
    logic [VW-1:0]     ent_offset;
    logic [VW-1:0]     ent_length;
    logic [VW:0]       diff;
    logic              hit;
    logic [VW-1:0]     hit_value;
    logic [VW-1:0]     set_min;
    logic [31:0]       stages_used;
    logic              wr_in_range;

    mrrm_table #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (tbl_rd_en),
        .i_rd_addr (r_iss_addr),
        .o_rd_data (tbl_rd_data)
    );

    // The memory keeps destination minus source, so a hit needs only one add.
    assign {ent_valid, ent_source, ent_offset, ent_length} = tbl_rd_data;
    assign diff      = {1'b0, r_value} - {1'b0, ent_source};
    assign hit       = r_rd_vld && ent_valid && !diff[VW] && (diff[VW-1:0] < ent_length);
    assign hit_value = r_value + ent_offset;

    assign stages_used = (32'(r_cfg) > STAGES) ? 32'(STAGES) : 32'(r_cfg);
    assign wr_in_range = (32'(i_stage_index) < STAGES)
                      && (32'(i_entry_index) < ENTRIES_PER_STAGE);
    assign set_min     = (!r_set_open || (r_value < r_run_min)) ? r_value : r_run_min;

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_iss_active  = r_iss_active;
        n_rd_vld      = r_rd_vld;
        n_run_min     = r_run_min;
        n_set_open    = r_set_open;
        n_out_valid   = 1'b0;
        n_iss_addr    = r_iss_addr;
        n_iss_entry   = r_iss_entry;
        n_iss_stage   = r_iss_stage;
        n_last_stg    = r_last_stg;
        n_dat_last    = r_dat_last;
        n_dat_stage   = r_dat_stage;
        n_value       = r_value;
        n_last_in_set = r_last_in_set;
        n_out_mapped  = r_out_mapped;
        n_out_min     = r_out_min;
        n_out_closed  = r_out_closed;
        tbl_wr_en     = 1'b0;
        tbl_wr_addr   = r_clr_addr;
        tbl_wr_data   = '0;
        tbl_rd_en     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                tbl_wr_en = 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_command == CMD_WRITE) begin
                        tbl_wr_en   = wr_in_range;
                        tbl_wr_addr = AW'(32'(i_stage_index) * ENTRIES_PER_STAGE
                                          + 32'(i_entry_index));
                        tbl_wr_data = {i_entry_enable, i_entry_source,
                                       i_entry_destination - i_entry_source,
                                       i_entry_length};
                    end else begin
                        n_value       = i_seed_value;
                        n_last_in_set = i_last_in_set;
                        n_rd_vld      = 1'b0;
                        n_iss_addr    = '0;
                        n_iss_entry   = '0;
                        n_iss_stage   = '0;
                        n_last_stg    = STG_W'(stages_used - 32'd1);
                        if (stages_used == 32'd0) begin
                            n_state = S_FINISH;
                        end else begin
                            n_iss_active = 1'b1;
                            n_state      = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_rd_vld = 1'b0;
                if (hit) begin
                    // The hit ends its stage; the scan restarts at the first entry of the next stage.
                    n_value = hit_value;
                    if (r_dat_stage == r_last_stg) begin
                        n_iss_active = 1'b0;
                        n_state      = S_FINISH;
                    end else begin
                        n_iss_active = 1'b1;
                        n_iss_stage  = r_dat_stage + 1'b1;
                        n_iss_entry  = '0;
                        n_iss_addr   = AW'((32'(r_dat_stage) + 32'd1) * ENTRIES_PER_STAGE);
                    end
                end else if (r_rd_vld && r_dat_last && (r_dat_stage == r_last_stg)) begin
                    n_iss_active = 1'b0;
                    n_state      = S_FINISH;
                end else if (r_iss_active) begin
                    tbl_rd_en   = 1'b1;
                    n_rd_vld    = 1'b1;
                    n_dat_stage = r_iss_stage;
                    n_dat_last  = (r_iss_entry == ENT_W'(ENTRIES_PER_STAGE - 1));
                    n_iss_addr  = r_iss_addr + 1'b1;
                    if (r_iss_entry == ENT_W'(ENTRIES_PER_STAGE - 1)) begin
                        n_iss_entry = '0;
                        if (r_iss_stage == r_last_stg) begin
                            n_iss_active = 1'b0;
                        end else begin
                            n_iss_stage = r_iss_stage + 1'b1;
                        end
                    end else begin
                        n_iss_entry = r_iss_entry + 1'b1;
                    end
                end
            end
            S_FINISH: begin
                n_out_valid  = 1'b1;
                n_out_mapped = r_value;
                n_out_min    = set_min;
                n_out_closed = r_last_in_set;
                n_run_min    = r_last_in_set ? '1 : set_min;
                n_set_open   = !r_last_in_set;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_cfg        <= CFG_RESET;
            r_iss_active <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_run_min    <= '1;
            r_set_open   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_iss_active <= n_iss_active;
            r_rd_vld     <= n_rd_vld;
            r_run_min    <= n_run_min;
            r_set_open   <= n_set_open;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss_addr    <= n_iss_addr;
        r_iss_entry   <= n_iss_entry;
        r_iss_stage   <= n_iss_stage;
        r_last_stg    <= n_last_stg;
        r_dat_last    <= n_dat_last;
        r_dat_stage   <= n_dat_stage;
        r_value       <= n_value;
        r_last_in_set <= n_last_in_set;
        r_out_mapped  <= n_out_mapped;
        r_out_min     <= n_out_min;
        r_out_closed  <= n_out_closed;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_strobe       = r_out_valid;
    assign o_mapped_value = r_out_mapped;
    assign o_set_minimum  = r_out_min;
    assign o_set_closed   = r_out_closed;

endmodule

/* src/mrrm_table.sv */
// ============================================================================
// mrrm_table
// Range entry memory: one write port, one read port, registered read data.
// Each word holds the valid bit, source base, offset and length of an entry.
// ============================================================================
module mrrm_table #(
    parameter int DEPTH = mrrm_pkg::STAGES_DEF * mrrm_pkg::ENTRIES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DW    = 3 * mrrm_pkg::VALUE_WIDTH_DEF + 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/mrrm_checker.sv */
// ============================================================================
// mrrm_checker
// Port-level checks of the range remapper, bound to the top level.
// ============================================================================
module mrrm_checker #(
    parameter int VALUE_WIDTH = mrrm_pkg::VALUE_WIDTH_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             i_command,
    input logic [mrrm_pkg::STAGE_IDX_W-1:0] i_stage_index,
    input logic [mrrm_pkg::ENTRY_IDX_W-1:0] i_entry_index,
    input logic                             i_entry_enable,
    input logic [VALUE_WIDTH-1:0]           i_entry_source,
    input logic [VALUE_WIDTH-1:0]           i_entry_destination,
    input logic [VALUE_WIDTH-1:0]           i_entry_length,
    input logic [VALUE_WIDTH-1:0]           i_seed_value,
    input logic                             i_last_in_set,
    input logic                             o_strobe,
    input logic [VALUE_WIDTH-1:0]           o_mapped_value,
    input logic [VALUE_WIDTH-1:0]           o_set_minimum,
    input logic                             o_set_closed,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [mrrm_pkg::CFG_W-1:0]       i_cfg_data
);
    import mrrm_pkg::*;

    // A result only ever ends a busy spell.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a preceding busy cycle");

    // A map item always occupies the block.
    a_map_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_MAP)) |=> busy)
        else $error("map item accepted but busy stayed low");

    // A table write finishes in its own cycle and gives no result.
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_WRITE)) |=> (!busy && !o_strobe))
        else $error("table write item caused busy or a result");

    // The set minimum never exceeds the value it includes.
    a_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_set_minimum <= o_mapped_value))
        else $error("set minimum above the mapped value");

endmodule

bind multi_stage_range_remap_min mrrm_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_mrrm_checker (.*);
